[rtl/core/crcs_pkg.sv]
// Shared constants, column tables and XOR-network helpers for the CRC-32C stream unit.
package crcs_pkg;

	localparam int unsigned BYTES_PER_WORD_DEF = 8;
	localparam int unsigned DATA_WORD_W        = 64;
	localparam int unsigned BYTE_COUNT_W       = 4;
	localparam int unsigned CRC_W              = 32;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F63B78;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

	typedef logic [CRC_W-1:0] col_tab_t [CRC_W];

	function automatic logic [CRC_W-1:0] crc_zero_bytes(logic [CRC_W-1:0] r, int unsigned k);
		logic [CRC_W-1:0] acc;
		acc = r;
		for (int unsigned i = 0; i < 8 * k; i++) begin
			acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
		end
		return acc;
	endfunction

	function automatic col_tab_t crc_cols(int unsigned k);
		col_tab_t cols;
		for (int unsigned j = 0; j < CRC_W; j++) begin
			cols[j] = crc_zero_bytes(CRC_W'(1) << j, k);
		end
		return cols;
	endfunction

	function automatic logic [CRC_W-1:0] crc_apply(col_tab_t cols, logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] acc;
		acc = '0;
		for (int unsigned j = 0; j < CRC_W; j++) begin
			if (v[j]) begin
				acc = acc ^ cols[j];
			end
		end
		return acc;
	endfunction

endpackage

[rtl/core/crcs_lane.sv]
// Byte lane: contribution of one aligned message byte to the remainder.
module crcs_lane
	import crcs_pkg::*;
#(
	parameter int unsigned ADV = 1
) (
	input  logic [7:0]       data_byte,
	output logic [CRC_W-1:0] part
);

	localparam col_tab_t COLS = crc_cols(ADV);

	assign part = crc_apply(COLS, {{(CRC_W-8){1'b0}}, data_byte});

endmodule

[rtl/core/crcs_merge.sv]
// Merge stage: advance the remainder by the byte count and fold in all byte lanes.
module crcs_merge
	import crcs_pkg::*;
#(
	parameter int unsigned BYTES_PER_WORD = BYTES_PER_WORD_DEF,
	localparam int unsigned DW = 8 * BYTES_PER_WORD,
	localparam int unsigned CW = $clog2(BYTES_PER_WORD + 1)
) (
	input  logic [DW-1:0]    aligned,
	input  logic [CW-1:0]    count,
	input  logic [CRC_W-1:0] rem,
	output logic [CRC_W-1:0] rem_next
);

	logic [CRC_W-1:0] parts [BYTES_PER_WORD];
	logic [CRC_W-1:0] adv   [BYTES_PER_WORD + 1];
	logic [CRC_W-1:0] data_sum;

	for (genvar p = 0; p < BYTES_PER_WORD; p++) begin : g_lane
		crcs_lane #(
			.ADV(BYTES_PER_WORD - p)
		) u_lane (
			.data_byte(aligned[8*p +: 8]),
			.part     (parts[p])
		);
	end

	for (genvar k = 0; k <= BYTES_PER_WORD; k++) begin : g_adv
		localparam col_tab_t COLS = crc_cols(k);
		assign adv[k] = crc_apply(COLS, rem);
	end

	always_comb begin
		data_sum = '0;
		for (int unsigned p = 0; p < BYTES_PER_WORD; p++) begin
			data_sum = data_sum ^ parts[p];
		end
	end

	assign rem_next = adv[count] ^ data_sum;

endmodule

[rtl/core/crc32c_stream_unit.sv]
// Top level of the CRC-32C stream unit: input alignment stage, remainder register, result register.
//
//  channel  dir  tdata (low bit up)                                  tlast
//  s_*      in   data_word[63:0], byte_count[67:64], zero pad 71:68  end_of_message
//  m_*      out  crc_value[31:0]                                     -
//
//  One transaction per cycle unless a last word waits in stage 1; its CRC then goes to the result register.
//  Stage 1 aligns the valid bytes to the top of the word; the remainder loop then folds all
//  byte lanes and the remainder advance into one update per cycle.
//  arst_n clears all valid flags and loads the remainder with all ones.
//  A last transaction waits in stage 1 only while the result register is full and stalled.
module crc32c_stream_unit
	import crcs_pkg::*;
#(
	parameter int unsigned BYTES_PER_WORD = BYTES_PER_WORD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // data_word[63:0], byte_count[67:64], pad[71:68]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // crc_value[31:0]
);

	localparam int unsigned DW = 8 * BYTES_PER_WORD;
	localparam int unsigned CW = $clog2(BYTES_PER_WORD + 1);
	localparam int unsigned SW = $clog2(DW + 1);

	logic [BYTE_COUNT_W-1:0] cnt_raw;
	logic [CW-1:0]           cnt_in;
	logic [SW-1:0]           shamt;
	logic [DW-1:0]           aligned_d;

	logic                    valid_s1;
	logic [DW-1:0]           aligned_s1;
	logic [CW-1:0]           cnt_s1;
	logic                    last_s1;

	logic [CRC_W-1:0]        remainder_q;
	logic [CRC_W-1:0]        rem_next;
	logic                    out_valid_q;
	logic [CRC_W-1:0]        crc_q;

	logic                    out_free;
	logic                    s1_fire;

	assign cnt_raw   = s_tdata[DATA_WORD_W +: BYTE_COUNT_W];
	assign cnt_in    = (cnt_raw > BYTE_COUNT_W'(BYTES_PER_WORD)) ?
		CW'(BYTES_PER_WORD) : CW'(cnt_raw);
	assign shamt     = SW'((BYTES_PER_WORD - 32'(cnt_in)) * 8);
	assign aligned_d = s_tdata[DW-1:0] << shamt;

	assign out_free = !out_valid_q || m_tready;
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || s1_fire;

	crcs_merge #(
		.BYTES_PER_WORD(BYTES_PER_WORD)
	) u_merge (
		.aligned (aligned_s1),
		.count   (cnt_s1),
		.rem     (remainder_q),
		.rem_next(rem_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			aligned_s1 <= aligned_d;
			cnt_s1     <= cnt_in;
			last_s1    <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remainder_q <= CRC_INIT;
		end else if (s1_fire) begin
			remainder_q <= last_s1 ? CRC_INIT : rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			crc_q <= rem_next ^ CRC_INIT;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = crc_q;

endmodule

[tb/sv/crc32c_checker.sv]
// Checker for the CRC-32C stream unit: predicts each message CRC and compares the results.
module crc32c_checker
	import crcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,   // data_word[63:0], byte_count[67:64], pad[71:68]
	input  logic        s_tlast,   // end_of_message
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // crc_value[31:0]
	output int          fail_count,
	output int          crc_backlog,
	output int          crcs_matched
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CRC_W-1:0] running_crc;
	logic [CRC_W-1:0] expected_crcs[$];

	function automatic logic [CRC_W-1:0] fold_word(logic [CRC_W-1:0] r,
			logic [DATA_WORD_W-1:0] w, logic [BYTE_COUNT_W-1:0] n);
		int unsigned lanes;
		lanes = (n > BYTES_PER_WORD_DEF) ? BYTES_PER_WORD_DEF : n;
		for (int unsigned b = 0; b < lanes; b++) begin
			r = r ^ CRC_W'(w[8*b +: 8]);
			for (int k = 0; k < 8; k++) begin
				r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			end
		end
		return r;
	endfunction

	initial begin
		fail_count   = 0;
		crc_backlog  = 0;
		crcs_matched = 0;
		running_crc  = CRC_INIT;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		logic [CRC_W-1:0] want;
		if (!arst_n) begin
			running_crc = CRC_INIT;
			expected_crcs.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				running_crc = fold_word(running_crc, s_tdata[DATA_WORD_W-1:0],
					s_tdata[DATA_WORD_W +: BYTE_COUNT_W]);
				if (s_tlast) begin
					expected_crcs.push_back(running_crc ^ CRC_INIT);
					running_crc = CRC_INIT;
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_crcs.size() == 0) begin
					$display("%0t: unexpected CRC result, expected none, actual %h",
						$time, m_tdata);
					fail_count++;
				end else begin
					want = expected_crcs.pop_front();
					if (m_tdata !== want) begin
						$display("%0t: CRC mismatch, expected %h, actual %h",
							$time, want, m_tdata);
						fail_count++;
					end else begin
						crcs_matched++;
					end
				end
			end
		end
		crc_backlog = expected_crcs.size();
	end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the CRC-32C stream unit: clock, reset, word stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WORD_W  = crcs_pkg::DATA_WORD_W;
	localparam int unsigned COUNT_W = crcs_pkg::BYTE_COUNT_W;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	int fail_count;
	int crc_backlog;
	int crcs_matched;
	int words_sent    = 0;
	int messages_sent = 0;
	bit calm          = 1'b0;

	always #1 clk = ~clk;

	crc32c_stream_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	crc32c_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.crc_backlog  (crc_backlog),
		.crcs_matched (crcs_matched)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 15);
		end
	end

	function automatic logic [63:0] random_word();
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_word(input logic [63:0] w, input logic [3:0] n, input logic last);
		while (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, n, w};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
		if (last) messages_sent++;
	endtask

	task automatic send_message(input int unsigned num_words);
		logic [3:0] n;
		for (int unsigned i = 0; i < num_words; i++) begin
			n = ($urandom_range(9) < 6) ? 4'd8 : 4'($urandom_range(15));
			send_word(random_word(), n, i == num_words - 1);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (crc_backlog != 0) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(64'h3837_3635_3433_3231, 4'd8, 1'b0);
		send_word(64'hFFFF_FFFF_FFFF_FF39, 4'd1, 1'b1);
		send_word(random_word(), 4'd0, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
		send_word(64'h0000_0000_0000_0000, 4'd8, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
		send_word(random_word(), 4'd0, 1'b0);
		send_word(random_word(), 4'd9, 1'b1);
		for (int n = 0; n < 16; n++) begin
			send_word(random_word(), 4'(n), (n % 3) == 2 || n == 15);
		end

		while (words_sent < 180) send_message($urandom_range(1, 6));
		drain_results();

		calm = 1'b1;
		while (words_sent < 320) send_message($urandom_range(1, 6));
		calm = 1'b0;

		send_message(24);
		while (words_sent < 475) begin
			if ($urandom_range(9) == 0) begin
				drain_results();
			end
			send_message($urandom_range(1, 8));
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (crc_backlog != 0) @(negedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d words in %0d messages with byte counts 0 to 15 and random stalls,",
			words_sent, messages_sent);
		$display("compared %0d CRC results against the predicted values.", crcs_matched);
		if (fail_count == 0 && crc_backlog == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("Verification failed");
		$finish;
	end

endmodule

[crc32c_stream_unit.f]
rtl/core/crcs_pkg.sv
rtl/core/crcs_lane.sv
rtl/core/crcs_merge.sv
rtl/core/crc32c_stream_unit.sv
tb/sv/crc32c_checker.sv
tb/sv/tb_top.sv
